/* rtl/core/pgs_pkg.sv */
package pgs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QUO_W     = 32;
  localparam int ROOT_W    = 34;
  localparam int SQ_W      = 2 * ROOT_W;
  localparam int NUM_W     = 96;

  localparam logic [2:0] REG_GRAV_CONST    = 3'd0;
  localparam logic [2:0] REG_PARTICLE_MASS = 3'd1;
  localparam logic [2:0] REG_SRC_X         = 3'd2;
  localparam logic [2:0] REG_SRC_Y         = 3'd3;
  localparam logic [2:0] REG_SRC_MASS      = 3'd4;
  localparam logic [2:0] REG_SRC_ACTIVE    = 3'd5;
  localparam logic [2:0] REG_TIME_STEP     = 3'd6;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               last_in;
  } pgs_in_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic               too_close;
    logic               last_out;
  } pgs_out_t;

endpackage

/* rtl/core/point_gravity_particle_step_unit.sv */
// Throughput: one particle per cycle while the skid register is empty; the sqrt and the two chained
// divider levels retire one quotient or root bit per stage, so the depth is set by those 34 + 32 + 32 stages.
// A stalled output parks one result in a skid register; in_ready is low while it is full.
// Reset (rst, synchronous) clears all valid bits and loads the register reset values.
module point_gravity_particle_step_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pgs_pkg::pgs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pgs_pkg::pgs_out_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_idx,
  input  logic [31:0]       cfg_data
);

  localparam int RW = pgs_pkg::ROOT_W;
  localparam int SW = pgs_pkg::SQ_W;
  localparam int NW = pgs_pkg::NUM_W;
  localparam int QW = pgs_pkg::QUO_W;

  typedef struct packed {
    pgs_pkg::pgs_in_t item;
    logic             act;
    logic             dxp;
    logic             dyp;
    logic [32:0]      ax;
    logic [32:0]      ay;
  } pre_t;

  typedef struct packed {
    pre_t          pre;
    logic          close;
    logic [RW-1:0] r;
  } mid_t;

  typedef struct packed {
    logic act;
    logic close;
    logic dxp;
    logic dyp;
  } flags_t;

  function automatic logic [31:0] sat32(input logic [33:0] x);
    if (!x[33] && x[32:31] != 2'b00) return 32'h7fff_ffff;
    else if (x[33] && x[32:31] != 2'b11) return 32'h8000_0000;
    else return x[31:0];
  endfunction

  // configuration
  logic [31:0] gravity, src_x, src_y, source_mass, time_step;
  logic        src_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity     <= 32'd65536;
      src_x       <= 32'd0;
      src_y       <= 32'd0;
      source_mass <= 32'd65536;
      src_active  <= 1'b0;
      time_step   <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_idx)
        pgs_pkg::REG_GRAV_CONST:    gravity <= cfg_data;
        // particle mass cancels out of the pull; nothing to hold
        pgs_pkg::REG_PARTICLE_MASS: ;
        pgs_pkg::REG_SRC_X:         src_x <= cfg_data;
        pgs_pkg::REG_SRC_Y:         src_y <= cfg_data;
        pgs_pkg::REG_SRC_MASS:      source_mass <= cfg_data;
        pgs_pkg::REG_SRC_ACTIVE:    src_active <= cfg_data[0];
        pgs_pkg::REG_TIME_STEP:     time_step <= cfg_data;
        default: ;
      endcase
    end
  end

  // G*M*dt, free running; settles long before an item reaches the divider
  logic [63:0]   gm, nlo, nhi;
  logic [NW-1:0] num;

  always_ff @(posedge clk) begin
    gm  <= 64'(gravity) * 64'(source_mass);
    nlo <= 64'(gm[31:0]) * 64'(time_step);
    nhi <= 64'(gm[63:32]) * 64'(time_step);
    num <= {nhi, 32'd0} + NW'(nlo);
  end

  logic en;
  logic skid_v;
  pgs_pkg::pgs_out_t skid_data;

  assign en       = !skid_v;
  assign in_ready = !skid_v;

  // offsets
  logic             s0_v, s0_act;
  pgs_pkg::pgs_in_t s0_item;
  logic [32:0]      s0_dx, s0_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (en) begin
      s0_v <= in_valid;
    end
    if (en) begin
      s0_item <= in_data;
      s0_act  <= src_active;
      s0_dx   <= {in_data.pos_x[31], in_data.pos_x} - {src_x[31], src_x};
      s0_dy   <= {in_data.pos_y[31], in_data.pos_y} - {src_y[31], src_y};
    end
  end

  // magnitudes
  logic s1_v;
  pre_t s1_pre;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= s0_v;
    end
    if (en) begin
      s1_pre.item <= s0_item;
      s1_pre.act  <= s0_act;
      s1_pre.dxp  <= !s0_dx[32] && (s0_dx != 33'd0);
      s1_pre.dyp  <= !s0_dy[32] && (s0_dy != 33'd0);
      s1_pre.ax   <= s0_dx[32] ? (33'd0 - s0_dx) : s0_dx;
      s1_pre.ay   <= s0_dy[32] ? (33'd0 - s0_dy) : s0_dy;
    end
  end

  // squares
  logic        s2_v;
  pre_t        s2_pre;
  logic [65:0] s2_sqx, s2_sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
    if (en) begin
      s2_pre <= s1_pre;
      s2_sqx <= 66'(s1_pre.ax) * 66'(s1_pre.ax);
      s2_sqy <= 66'(s1_pre.ay) * 66'(s1_pre.ay);
    end
  end

  // integer square root, one root bit per stage; sq_rem holds s - root^2
  logic          sq_v    [0:RW];
  logic [SW-1:0] sq_rem  [0:RW];
  logic [RW-1:0] sq_root [0:RW];
  pre_t          sq_pay  [0:RW];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= s2_v;
    end
    if (en) begin
      sq_rem[0]  <= SW'(s2_sqx) + SW'(s2_sqy);
      sq_root[0] <= '0;
      sq_pay[0]  <= s2_pre;
    end
  end

  for (genvar j = 1; j <= RW; j++) begin : g_sqrt
    localparam int B = RW - j;
    logic [SW-1:0] trial;
    assign trial = (SW'(sq_root[j-1]) << (B + 1)) | (SW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[j] <= 1'b0;
      end else if (en) begin
        sq_v[j] <= sq_v[j-1];
      end
      if (en) begin
        sq_pay[j] <= sq_pay[j-1];
        if (sq_rem[j-1] >= trial) begin
          sq_rem[j]  <= sq_rem[j-1] - trial;
          sq_root[j] <= sq_root[j-1] | (RW'(1) << B);
        end else begin
          sq_rem[j]  <= sq_rem[j-1];
          sq_root[j] <= sq_root[j-1];
        end
      end
    end
  end

  // r squared
  logic          rr_v;
  logic [SW-1:0] rr;
  mid_t          rr_mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rr_v <= 1'b0;
    end else if (en) begin
      rr_v <= sq_v[RW];
    end
    if (en) begin
      rr           <= SW'(sq_root[RW]) * SW'(sq_root[RW]);
      rr_mid.pre   <= sq_pay[RW];
      rr_mid.r     <= sq_root[RW];
      rr_mid.close <= sq_pay[RW].act && (sq_root[RW] == '0);
    end
  end

  // a = G*M*dt / r^2, saturated
  logic                    da_v;
  logic [QW-1:0]           da_q;
  logic [$bits(mid_t)-1:0] da_pay;
  mid_t                    da_mid;

  pgs_udiv_pipe #(.NW(NW), .DW(SW), .PW($bits(mid_t))) u_div_acc (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (rr_v),
    .num      (num),
    .den      (rr),
    .pay_in   (rr_mid),
    .out_valid(da_v),
    .quo      (da_q),
    .pay_out  (da_pay)
  );

  assign da_mid = mid_t'(da_pay);

  // |d| * a
  logic        ml_v;
  logic [64:0] ml_x, ml_y;
  mid_t        ml_mid;
  flags_t      ml_flags;

  assign ml_flags = '{act: ml_mid.pre.act, close: ml_mid.close,
                      dxp: ml_mid.pre.dxp, dyp: ml_mid.pre.dyp};

  always_ff @(posedge clk) begin
    if (rst) begin
      ml_v <= 1'b0;
    end else if (en) begin
      ml_v <= da_v;
    end
    if (en) begin
      ml_mid <= da_mid;
      ml_x   <= 65'(da_mid.pre.ax) * 65'(da_q);
      ml_y   <= 65'(da_mid.pre.ay) * 65'(da_q);
    end
  end

  // dv = |d| * a / r; x lane carries the item, y lane the flags
  logic                             dvx_v, dvy_v;
  logic [QW-1:0]                    dvx_q, dvy_q;
  logic [$bits(pgs_pkg::pgs_in_t)-1:0] dvx_pay;
  logic [$bits(flags_t)-1:0]        dvy_pay;
  pgs_pkg::pgs_in_t                 dv_item;
  flags_t                           dv_flags;

  pgs_udiv_pipe #(.NW(65), .DW(RW), .PW($bits(pgs_pkg::pgs_in_t))) u_div_dvx (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (ml_v),
    .num      (ml_x),
    .den      (ml_mid.r),
    .pay_in   (ml_mid.pre.item),
    .out_valid(dvx_v),
    .quo      (dvx_q),
    .pay_out  (dvx_pay)
  );

  pgs_udiv_pipe #(.NW(65), .DW(RW), .PW($bits(flags_t))) u_div_dvy (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (ml_v),
    .num      (ml_y),
    .den      (ml_mid.r),
    .pay_in   (ml_flags),
    .out_valid(dvy_v),
    .quo      (dvy_q),
    .pay_out  (dvy_pay)
  );

  assign dv_item  = pgs_pkg::pgs_in_t'(dvx_pay);
  assign dv_flags = flags_t'(dvy_pay);

  // velocity update
  logic             f1_v, f1_close;
  pgs_pkg::pgs_in_t f1_item;
  logic [31:0]      f1_vx, f1_vy;
  logic             pull;
  logic [33:0]      vx_ext, vy_ext, dvx_ext, dvy_ext, vx_sum, vy_sum;

  assign pull    = dv_flags.act && !dv_flags.close;
  assign vx_ext  = {{2{dv_item.vel_x[31]}}, dv_item.vel_x};
  assign vy_ext  = {{2{dv_item.vel_y[31]}}, dv_item.vel_y};
  assign dvx_ext = 34'(dvx_q);
  assign dvy_ext = 34'(dvy_q);
  assign vx_sum  = !pull ? vx_ext : (dv_flags.dxp ? vx_ext - dvx_ext : vx_ext + dvx_ext);
  assign vy_sum  = !pull ? vy_ext : (dv_flags.dyp ? vy_ext - dvy_ext : vy_ext + dvy_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
    end else if (en) begin
      f1_v <= dvx_v;
    end
    if (en) begin
      f1_item  <= dv_item;
      f1_close <= dv_flags.act && dv_flags.close;
      f1_vx    <= sat32(vx_sum);
      f1_vy    <= sat32(vy_sum);
    end
  end

  // position update
  logic              f2_v;
  pgs_pkg::pgs_out_t f2_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_v <= 1'b0;
    end else if (en) begin
      f2_v <= f1_v;
    end
    if (en) begin
      f2_out.new_pos_x <= sat32({{2{f1_item.pos_x[31]}}, f1_item.pos_x}
                                + {{2{f1_vx[31]}}, f1_vx});
      f2_out.new_pos_y <= sat32({{2{f1_item.pos_y[31]}}, f1_item.pos_y}
                                + {{2{f1_vy[31]}}, f1_vy});
      f2_out.new_vel_x <= f1_vx;
      f2_out.new_vel_y <= f1_vy;
      f2_out.too_close <= f1_close;
      f2_out.last_out  <= f1_item.last_in;
    end
  end

  // output register with one-entry skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (skid_v) begin
      if (out_ready) begin
        out_valid <= 1'b1;
        out_data  <= skid_data;
        skid_v    <= 1'b0;
      end
    end else if (!out_valid || out_ready) begin
      out_valid <= f2_v;
      out_data  <= f2_out;
    end else if (f2_v) begin
      // output held: park the result leaving the pipeline
      skid_v    <= 1'b1;
      skid_data <= f2_out;
    end
  end

  a_skid_has_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_valid)
    else $error("skid holds a result while output is empty");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    skid_v && out_ready |=> !skid_v && out_valid)
    else $error("skid not drained on output transfer");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !in_ready && !out_ready |=> !in_ready)
    else $error("pipeline released while output still stalled");

endmodule

/* rtl/core/pgs_udiv_pipe.sv */
module pgs_udiv_pipe #(
  parameter int NW = pgs_pkg::NUM_W,
  parameter int DW = pgs_pkg::SQ_W,
  parameter int PW = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [NW-1:0]             num,
  input  logic [DW-1:0]             den,
  input  logic [PW-1:0]             pay_in,
  output logic                      out_valid,
  output logic [pgs_pkg::QUO_W-1:0] quo,
  output logic [PW-1:0]             pay_out
);

  localparam int QW = pgs_pkg::QUO_W;
  localparam int W  = (NW > DW + QW) ? NW : DW + QW;

  logic          v   [0:QW];
  logic [W-1:0]  rem [0:QW];
  logic [DW-1:0] dd  [0:QW];
  logic [QW-1:0] q   [0:QW];
  logic          ov  [0:QW];
  logic [PW-1:0] pp  [0:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
    if (en) begin
      rem[0] <= W'(num);
      dd[0]  <= den;
      q[0]   <= '0;
      // quotient would not fit: saturate at the end
      ov[0]  <= W'(num) >= (W'(den) << QW);
      pp[0]  <= pay_in;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_step
    localparam int KB = QW - j;
    logic [W-1:0] trial;
    assign trial = W'(dd[j-1]) << KB;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (en) begin
        v[j] <= v[j-1];
      end
      if (en) begin
        dd[j] <= dd[j-1];
        ov[j] <= ov[j-1];
        pp[j] <= pp[j-1];
        if (rem[j-1] >= trial) begin
          rem[j] <= rem[j-1] - trial;
          q[j]   <= q[j-1] | (QW'(1) << KB);
        end else begin
          rem[j] <= rem[j-1];
          q[j]   <= q[j-1];
        end
      end
    end
  end

  assign out_valid = v[QW];
  assign quo       = ov[QW] ? '1 : q[QW];
  assign pay_out   = pp[QW];

endmodule
